@@ src/trsf_pkg.sv @@
// Shared types and constants for the two-reader shared FIFO.
package trsf_pkg;

  // Ring capacity in records; a power of two so positions wrap by truncation
  localparam int DEPTH  = 16;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int POS_W  = SLOT_W + 1;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NO_NEW  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    op_t         op;
    logic        consumer;
    logic        producer_done;
    logic [15:0] src_id;
    logic [63:0] value_bits;
    logic [31:0] time_stamp;
  } in_req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_sensor_id;
    logic [63:0] out_value;
    logic [31:0] out_time;
  } out_rsp_t;

  typedef struct packed {
    logic [15:0] src_id;
    logic [63:0] value;
    logic [31:0] stamp;
  } rec_t;

endpackage

@@ src/trsf_in_if.sv @@
// Request channel: valid/ready handshake carrying one FIFO operation.
interface trsf_in_if import trsf_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/trsf_out_if.sv @@
// Result channel: valid/ready handshake carrying one status and record.
interface trsf_out_if import trsf_pkg::*; ();
  logic     valid;
  logic     ready;
  out_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/two_reader_shared_fifo_core.sv @@
// Two-reader shared FIFO of sensor records: pointer control, record store, result register.
//
//  channel   dir  handshake            payload
//  in_chan   in   valid/ready          op, consumer, producer_done, src_id, value_bits,
//                                      time_stamp
//  out_chan  out  valid/ready          status, out_sensor_id, out_value, out_time
//
// Pointers update at the accepting edge and the record store is read at that same edge into the
// result register, so one request enters per cycle while the result side is not stalled.
// Reset clears all four ring positions and the result valid; record storage is not cleared.
// While a result waits and out_chan.ready is low, in_chan.ready stays low.
module two_reader_shared_fifo_core import trsf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  trsf_in_if.sink          in_chan,
  trsf_out_if.source       out_chan
);

  pos_t    head_r, head_nxt;
  pos_t    tail_r, tail_nxt;
  pos_t    rp_data_r, rp_data_nxt;
  pos_t    rp_stor_r, rp_stor_nxt;

  logic    out_valid_r;
  status_t out_status_r;
  logic    out_rec_r;
  rec_t    rd_data_r;

  rec_t    mem [DEPTH];

  logic    accept;
  pos_t    count;
  logic    empty;
  logic    full;
  pos_t    rp_sel;
  pos_t    seen_data;
  pos_t    seen_stor;
  pos_t    seen_both;
  logic    unseen;
  status_t status_c;
  logic    rec_c;
  logic    wr_en;
  slot_t   rd_addr;
  in_req_t req;

  assign req     = in_chan.data;
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept  = in_chan.valid && in_chan.ready;

  // Ring occupancy and per-consumer progress
  assign count     = tail_r - head_r;
  assign empty     = (count == '0);
  assign full      = (count >= pos_t'(DEPTH));
  assign rp_sel    = req.consumer ? rp_stor_r : rp_data_r;
  assign seen_data = rp_data_r - head_r;
  assign seen_stor = rp_stor_r - head_r;
  assign seen_both = (seen_data < seen_stor) ? seen_data : seen_stor;
  assign unseen    = (rp_sel != tail_r);

  // Decode the request and compute next positions
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    rp_data_nxt = rp_data_r;
    rp_stor_nxt = rp_stor_r;
    status_c    = ST_OK;
    rec_c       = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = rp_sel[SLOT_W-1:0];
    if (accept) begin
      unique case (req.op)
        OP_INSERT: begin
          if (full) begin
            status_c = ST_FULL;
          end else begin
            wr_en    = 1'b1;
            tail_nxt = tail_r + pos_t'(1);
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            status_c = ST_EMPTY;
          end else begin
            rec_c    = 1'b1;
            rd_addr  = head_r[SLOT_W-1:0];
            head_nxt = head_r + pos_t'(1);
            if (rp_data_r == head_r) rp_data_nxt = head_r + pos_t'(1);
            if (rp_stor_r == head_r) rp_stor_nxt = head_r + pos_t'(1);
          end
        end
        OP_READ: begin
          if (empty) begin
            status_c = ST_EMPTY;
          end else if (req.producer_done && (seen_both != '0)) begin
            // drop a single fully seen record
            head_nxt = head_r + pos_t'(1);
            status_c = ST_NO_NEW;
          end else begin
            // reclaim everything both readers have seen
            head_nxt = head_r + seen_both;
            if (!unseen) begin
              status_c = ST_NO_NEW;
            end else begin
              rec_c = 1'b1;
              if (req.consumer) begin
                rp_stor_nxt = rp_stor_r + pos_t'(1);
              end else begin
                rp_data_nxt = rp_data_r + pos_t'(1);
              end
            end
          end
        end
        OP_QUERY: begin
          if (empty) begin
            status_c = ST_EMPTY;
          end else if (!unseen) begin
            status_c = ST_NO_NEW;
          end
        end
        default: status_c = ST_OK;
      endcase
    end
  end

  // Ring positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      rp_data_r <= '0;
      rp_stor_r <= '0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      rp_data_r <= rp_data_nxt;
      rp_stor_r <= rp_stor_nxt;
    end
  end

  // Record store: write at the tail slot on insert
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r[SLOT_W-1:0]] <= '{src_id: req.src_id,
                                   value:  req.value_bits,
                                   stamp:  req.time_stamp};
    end
  end

  // Record store: registered read, held while the result stalls
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_c;
      out_rec_r    <= rec_c;
    end
  end

  // Zero the record fields when no record is returned
  assign out_chan.valid              = out_valid_r;
  assign out_chan.data.status        = out_status_r;
  assign out_chan.data.out_sensor_id = out_rec_r ? rd_data_r.src_id : '0;
  assign out_chan.data.out_value     = out_rec_r ? rd_data_r.value  : '0;
  assign out_chan.data.out_time      = out_rec_r ? rd_data_r.stamp  : '0;

  // Occupancy never exceeds the ring capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_t'(tail_r - head_r) <= pos_t'(DEPTH)))
    else $error("ring occupancy above capacity");

  // Each read position stays between head and tail
  a_rp_data_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_t'(rp_data_r - head_r) <= pos_t'(tail_r - head_r)))
    else $error("data reader position outside ring");

  a_rp_stor_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_t'(rp_stor_r - head_r) <= pos_t'(tail_r - head_r)))
    else $error("storage reader position outside ring");

  // A rejected insert leaves the tail where it was
  a_full_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && req.op == OP_INSERT && full) |=> (tail_r == $past(tail_r)))
    else $error("tail moved on insert into full ring");

endmodule

@@ bench/tb_two_reader_shared_fifo_core.sv @@
// Self-checking bench for the two-reader shared FIFO: directed and random requests.
module tb_two_reader_shared_fifo_core;
  import trsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n;

  trsf_in_if  in_chan ();
  trsf_out_if out_chan ();

  two_reader_shared_fifo_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow copy of the ring and its positions
  rec_t shadow_rec [DEPTH];
  pos_t shadow_head;
  pos_t shadow_tail;
  pos_t shadow_rd [2];

  out_rsp_t pending_results [$];
  int       err_count;
  int       cycle_count;
  bit       steady_flow;
  int       hold_ticket;

  always #10 clk = ~clk;

  // Work out the result of one request and advance the shadow state
  function automatic out_rsp_t fifo_result(in_req_t r);
    out_rsp_t res;
    rec_t     rec;
    pos_t     held;
    pos_t     seen0;
    pos_t     seen1;
    pos_t     both;
    pos_t     old_head;
    bit       give;
    res        = '0;
    res.status = ST_OK;
    give       = 1'b0;
    held       = shadow_tail - shadow_head;
    case (r.op)
      OP_INSERT: begin
        if (held >= pos_t'(DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          shadow_rec[shadow_tail[SLOT_W-1:0]] = '{r.src_id, r.value_bits, r.time_stamp};
          shadow_tail = shadow_tail + pos_t'(1);
        end
      end
      OP_REMOVE: begin
        if (held == '0) begin
          res.status = ST_EMPTY;
        end else begin
          rec      = shadow_rec[shadow_head[SLOT_W-1:0]];
          give     = 1'b1;
          old_head = shadow_head;
          shadow_head = shadow_head + pos_t'(1);
          // clamp any reader parked on the popped record
          if (shadow_rd[0] == old_head) shadow_rd[0] = shadow_head;
          if (shadow_rd[1] == old_head) shadow_rd[1] = shadow_head;
        end
      end
      OP_READ: begin
        if (held == '0) begin
          res.status = ST_EMPTY;
        end else begin
          seen0 = shadow_rd[0] - shadow_head;
          seen1 = shadow_rd[1] - shadow_head;
          both  = (seen0 < seen1) ? seen0 : seen1;
          if (r.producer_done && both != '0) begin
            // producer gone: drop a single fully seen record only
            shadow_head = shadow_head + pos_t'(1);
            res.status  = ST_NO_NEW;
          end else begin
            shadow_head = shadow_head + both;
            if (shadow_rd[r.consumer] == shadow_tail) begin
              res.status = ST_NO_NEW;
            end else begin
              rec  = shadow_rec[shadow_rd[r.consumer][SLOT_W-1:0]];
              give = 1'b1;
              shadow_rd[r.consumer] = shadow_rd[r.consumer] + pos_t'(1);
            end
          end
        end
      end
      default: begin
        if (held == '0) res.status = ST_EMPTY;
        else if (shadow_rd[r.consumer] == shadow_tail) res.status = ST_NO_NEW;
      end
    endcase
    if (give) begin
      res.out_sensor_id = rec.src_id;
      res.out_value     = rec.value;
      res.out_time      = rec.stamp;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Compare each accepted result, then record the request accepted at this edge
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result status", out_chan.data.status, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_chan.data.status !== want.status)
            report_mismatch("status", out_chan.data.status, want.status);
          if (out_chan.data.out_sensor_id !== want.out_sensor_id)
            report_mismatch("sensor id", out_chan.data.out_sensor_id, want.out_sensor_id);
          if (out_chan.data.out_value !== want.out_value)
            report_mismatch("value", out_chan.data.out_value, want.out_value);
          if (out_chan.data.out_time !== want.out_time)
            report_mismatch("timestamp", out_chan.data.out_time, want.out_time);
        end
      end
      if (in_chan.valid && in_chan.ready)
        pending_results.push_back(fifo_result(in_chan.data));
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls, plus long hold-offs on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (!rst_n) begin
        out_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= steady_flow || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_request(in_req_t r);
    int gap;
    if (!steady_flow && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        in_chan.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.data  <= r;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  function automatic in_req_t make_request(op_t op, logic consumer, logic done,
                                           logic [15:0] id, logic [63:0] val,
                                           logic [31:0] stamp);
    in_req_t r;
    r.op            = op;
    r.consumer      = consumer;
    r.producer_done = done;
    r.src_id        = id;
    r.value_bits    = val;
    r.time_stamp    = stamp;
    return r;
  endfunction

  function automatic in_req_t random_request(int insert_pct, int read_pct);
    int   pick;
    op_t  op;
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) op = OP_INSERT;
    else if (pick < insert_pct + read_pct) op = OP_READ;
    else if (pick < insert_pct + read_pct + (100 - insert_pct - read_pct) / 2) op = OP_QUERY;
    else op = OP_REMOVE;
    return make_request(op, 1'($urandom_range(0, 1)), $urandom_range(0, 99) < 30,
                        16'($urandom), {$urandom, $urandom}, $urandom);
  endfunction

  // Empty buffer answers for every operation that needs a record
  task automatic test_empty_buffer();
    send_request(make_request(OP_REMOVE, 1'b0, 1'b0, '0, '0, '0));
    send_request(make_request(OP_READ, 1'b1, 1'b1, '1, '1, '1));
    send_request(make_request(OP_QUERY, 1'b0, 1'b0, '0, '0, '0));
  endtask

  // Fill the ring with extreme field values, then overflow it once
  task automatic test_fill_to_full();
    logic [15:0] id;
    logic [63:0] val;
    logic [31:0] stamp;
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: begin id = '0;      val = '0;                    stamp = '0;          end
        1: begin id = '1;      val = '1;                    stamp = '1;          end
        2: begin id = 16'h5555; val = 64'hAAAA_AAAA_AAAA_AAAA; stamp = 32'h5555_5555; end
        default: begin id = 16'hAAAA; val = 64'h5555_5555_5555_5555; stamp = 32'hAAAA_AAAA; end
      endcase
      send_request(make_request(OP_INSERT, 1'b0, 1'b0, id, val, stamp));
    end
    send_request(make_request(OP_INSERT, 1'b1, 1'b0, 16'h1234, '1, '1));
  endtask

  // Both readers see the head, then a done-read drops it, then remove clamps readers
  task automatic test_reader_positions();
    send_request(make_request(OP_READ, 1'b0, 1'b0, '0, '0, '0));
    send_request(make_request(OP_READ, 1'b1, 1'b1, '0, '0, '0));
    send_request(make_request(OP_READ, 1'b0, 1'b1, '0, '0, '0));
    send_request(make_request(OP_REMOVE, 1'b1, 1'b0, '0, '0, '0));
    send_request(make_request(OP_QUERY, 1'b1, 1'b0, '0, '0, '0));
  endtask

  // Hold off the result side while requests keep coming, so input stalls
  task automatic test_backpressure();
    steady_flow = 1'b1;
    hold_ticket++;
    for (int i = 0; i < 30; i++) send_request(random_request(50, 30));
    steady_flow = 1'b0;
  endtask

  // Insert-heavy traffic that keeps the ring near full
  task automatic test_random_fill(int n);
    for (int i = 0; i < n; i++) send_request(random_request(65, 20));
  endtask

  // Read-heavy traffic that drains and reclaims
  task automatic test_random_drain(int n);
    for (int i = 0; i < n; i++) send_request(random_request(15, 55));
  endtask

  // Balanced traffic, the first stretch with no idling at all
  task automatic test_random_mixed(int n);
    for (int i = 0; i < n; i++) begin
      steady_flow = (i < 80);
      send_request(random_request(40, 35));
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    err_count     = 0;
    cycle_count   = 0;
    steady_flow   = 1'b0;
    hold_ticket   = 0;
    shadow_head   = '0;
    shadow_tail   = '0;
    shadow_rd[0]  = '0;
    shadow_rd[1]  = '0;
    rst_n         = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_buffer();
    test_fill_to_full();
    test_reader_positions();
    test_backpressure();
    test_random_fill(100);
    test_random_drain(100);
    test_random_mixed(200);

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (err_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
